### rtl/core/dg_pkg.sv
// shared widths, codes and table entry types for the displacement gate
package dg_pkg;

    localparam int ID_W       = 10;
    localparam int ID_EXT_W   = 17;
    localparam int SPACE_W    = 8;
    localparam int STAMP_W    = 62;
    localparam int POS_W      = 20;
    localparam int DIFF_W     = 21;
    localparam int PROD_W     = 42;
    localparam int SQ_W       = 40;
    localparam int MOVED_W    = 42;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 62;

    // opcodes
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 1'b1;

    // one table entry; moved distance kept as its two squared components
    typedef struct packed {
        logic                      valid;
        logic [SPACE_W-1:0]        space;
        logic [STAMP_W-1:0]        stamp;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic [SQ_W-1:0]           sq_x;
        logic [SQ_W-1:0]           sq_y;
    } t_entry;

    // fields of an update transaction
    typedef struct packed {
        logic [SPACE_W-1:0]        space;
        logic [STAMP_W-1:0]        stamp;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
    } t_upd;

endpackage

### rtl/core/dg_if.sv
// valid/ready channel interfaces for the displacement gate
interface dg_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [dg_pkg::ID_W-1:0]           first_ant;
    logic [dg_pkg::ID_W-1:0]           second_ant;
    logic [dg_pkg::SPACE_W-1:0]        space_id;
    logic [dg_pkg::STAMP_W-1:0]        frame_time;
    logic signed [dg_pkg::POS_W-1:0]   pos_x;
    logic signed [dg_pkg::POS_W-1:0]   pos_y;

    modport source (
        output valid, opcode, first_ant, second_ant, space_id, frame_time, pos_x, pos_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, first_ant, second_ant, space_id, frame_time, pos_x, pos_y,
        output ready
    );
endinterface

interface dg_out_if;
    logic valid;
    logic ready;
    logic pair_pass;

    modport source (
        output valid, pair_pass,
        input  ready
    );
    modport sink (
        input  valid, pair_pass,
        output ready
    );
endinterface

### rtl/core/dg_motion.sv
// new table entry for an update: gating and squared displacement components
module dg_motion (
    input  dg_pkg::t_entry                 i_prev,
    input  dg_pkg::t_upd                   i_upd,
    input  logic [dg_pkg::STAMP_W-1:0]     i_min_gap,
    output dg_pkg::t_entry                 o_next
);

    logic signed [dg_pkg::DIFF_W-1:0]  dx;
    logic signed [dg_pkg::DIFF_W-1:0]  dy;
    logic signed [dg_pkg::PROD_W-1:0]  px;
    logic signed [dg_pkg::PROD_W-1:0]  py;
    logic [dg_pkg::STAMP_W-1:0]        gap;
    logic                              moved;

    // coordinate differences and their squares
    always_comb begin
        dx = {i_upd.x[dg_pkg::POS_W-1], i_upd.x} - {i_prev.x[dg_pkg::POS_W-1], i_prev.x};
        dy = {i_upd.y[dg_pkg::POS_W-1], i_upd.y} - {i_prev.y[dg_pkg::POS_W-1], i_prev.y};
        px = dx * dx;
        py = dy * dy;
    end

    // displacement counts only for a known entry in the same space after a long enough gap
    always_comb begin
        gap   = i_upd.stamp - i_prev.stamp;
        moved = i_prev.valid && (i_prev.space == i_upd.space) &&
                (i_upd.stamp > i_prev.stamp) && (gap > i_min_gap);
    end

    // entry written back
    always_comb begin
        o_next.valid = 1'b1;
        o_next.space = i_upd.space;
        o_next.stamp = i_upd.stamp;
        o_next.x     = i_upd.x;
        o_next.y     = i_upd.y;
        o_next.sq_x  = moved ? px[dg_pkg::SQ_W-1:0] : '0;
        o_next.sq_y  = moved ? py[dg_pkg::SQ_W-1:0] : '0;
    end

endmodule

### rtl/core/displacement_gate.sv
// displacement gate: per-object motion table with pair query
// update: read at the accept edge, written back in the cycle after it
// query: two reads of the single-port table, result registered in S_Q2 once the output is free
// a new transaction waits until the one before has finished with the single table port
// reset (synchronous, active low) starts a pass that clears every table entry with input ready low;
// configuration writes are taken during that pass, registers reset to zero
module displacement_gate #(
    parameter int MAX_OBJECTS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    dg_in_if.sink                             i_in,
    dg_out_if.source                          o_out
);

    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_OBJECTS - 1);
    localparam logic [dg_pkg::ID_EXT_W-1:0] ID_LIMIT = dg_pkg::ID_EXT_W'(MAX_OBJECTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_U1,
        S_Q1,
        S_Q2
    } t_state;

    t_state                          r_state;
    t_state                          n_dispatch;
    logic [AW-1:0]                   r_clr_addr;
    logic [AW-1:0]                   r_addr_a;
    logic [AW-1:0]                   r_addr_b;
    logic                            r_ok_a;
    logic                            r_ok_b;
    dg_pkg::t_upd                    r_upd;
    logic                            r_fail_a;
    logic                            r_out_valid;
    logic                            r_pass;
    logic [dg_pkg::MOVED_W-1:0]      r_threshold;
    logic [dg_pkg::STAMP_W-1:0]      r_min_gap;

    dg_pkg::t_entry                  r_mem [MAX_OBJECTS];
    dg_pkg::t_entry                  r_rd;
    dg_pkg::t_entry                  upd_next;
    dg_pkg::t_upd                    in_upd;

    logic [dg_pkg::ID_EXT_W-1:0]     id_a_ext;
    logic [dg_pkg::ID_EXT_W-1:0]     id_b_ext;
    logic                            in_ok_a;
    logic                            in_ok_b;
    logic                            in_ready;
    logic                            in_fire;
    logic                            out_free;
    logic [dg_pkg::MOVED_W-1:0]      moved_sum;
    logic                            fail_rd;
    logic                            mem_we;
    logic [AW-1:0]                   mem_addr;
    dg_pkg::t_entry                  mem_wdata;

    // object ids against table depth
    always_comb begin
        id_a_ext = {{(dg_pkg::ID_EXT_W - dg_pkg::ID_W){1'b0}}, i_in.first_ant};
        id_b_ext = {{(dg_pkg::ID_EXT_W - dg_pkg::ID_W){1'b0}}, i_in.second_ant};
        in_ok_a  = id_a_ext < ID_LIMIT;
        in_ok_b  = id_b_ext < ID_LIMIT;
    end

    // input fields of an update
    always_comb begin
        in_upd.space = i_in.space_id;
        in_upd.stamp = i_in.frame_time;
        in_upd.x     = i_in.pos_x;
        in_upd.y     = i_in.pos_y;
    end

    // handshake
    assign out_free    = !r_out_valid || o_out.ready;
    assign in_ready    = (r_state == S_IDLE) || ((r_state == S_Q2) && out_free);
    assign in_fire     = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.pair_pass = r_pass;

    // state entered on an accepted transaction
    always_comb begin
        if (i_in.opcode == dg_pkg::OP_QUERY) begin
            n_dispatch = S_Q1;
        end else if (in_ok_a) begin
            n_dispatch = S_U1;
        end else begin
            n_dispatch = S_IDLE;
        end
    end

    // threshold test on the entry just read
    always_comb begin
        moved_sum = dg_pkg::MOVED_W'(r_rd.sq_x) + dg_pkg::MOVED_W'(r_rd.sq_y);
        fail_rd   = r_rd.valid && (moved_sum > r_threshold);
    end

    // update arithmetic on the entry read at accept
    dg_motion u_motion (
        .i_prev    (r_rd),
        .i_upd     (r_upd),
        .i_min_gap (r_min_gap),
        .o_next    (upd_next)
    );

    // table port select; a stalled query keeps re-reading its second entry
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_addr_b;
        mem_wdata = upd_next;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
            end
            S_U1: begin
                mem_we   = 1'b1;
                mem_addr = r_addr_a;
            end
            default: begin
                mem_addr = r_addr_b;
            end
        endcase
        if (in_fire) begin
            mem_addr = id_a_ext[AW-1:0];
        end
    end

    // single-port table with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_min_gap   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dg_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[dg_pkg::MOVED_W-1:0];
                dg_pkg::CFG_MIN_GAP:   r_min_gap   <= i_cfg_data[dg_pkg::STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_addr_a <= id_a_ext[AW-1:0];
            r_addr_b <= id_b_ext[AW-1:0];
            r_ok_a   <= in_ok_a;
            r_ok_b   <= in_ok_b;
            r_upd    <= in_upd;
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result valid: raised when a query completes, dropped when taken
            if ((r_state == S_Q2) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= n_dispatch;
                    end
                end
                S_U1: begin
                    r_state <= S_IDLE;
                end
                S_Q1: begin
                    r_fail_a <= r_ok_a && fail_rd;
                    r_state  <= S_Q2;
                end
                S_Q2: begin
                    if (out_free) begin
                        r_pass      <= !(r_fail_a || (r_ok_b && fail_rd));
                        r_state     <= in_fire ? n_dispatch : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // a result appears only when a query finishes
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_Q2))
        else $error("result raised outside query completion");

    // the table is written only by the clearing pass or an update
    a_write_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> ((r_state == S_U1) || (r_state == S_CLEAR)))
        else $error("table write outside update or clear");

    // an update writes back once and returns to idle
    a_update_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U1) |=> (r_state == S_IDLE))
        else $error("update write-back not followed by idle");

    // a stalled query keeps its second entry on the read port
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_Q2) && !out_free) |-> (mem_addr == r_addr_b))
        else $error("stalled query lost its read address");

    // no transaction during the clearing pass
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !in_fire)
        else $error("transaction accepted during table clear");
`endif

endmodule

### tb/dg_pair_checker.sv
// passive checker for the displacement gate: motion table predictor and pair_pass comparison
`timescale 1ns / 1ps

module dg_pair_checker #(
    parameter int N_OBJ = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    dg_in_if                                  i_in_mon,
    dg_out_if                                 i_out_mon,
    output int                                o_failures,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_blocked
);
    import dg_pkg::*;

    // one tracked object as the predictor sees it
    typedef struct {
        bit                        tracked;
        logic [SPACE_W-1:0]        space;
        logic [STAMP_W-1:0]        stamp;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic [MOVED_W-1:0]        moved;
    } t_track_rec;

    t_track_rec           track_tab [N_OBJ];
    logic [MOVED_W-1:0]   limit_sq;
    logic [STAMP_W-1:0]   gap_min;
    bit                   pass_due [$];

    // squared distance between two Q16.4 points, Q.8 result
    function automatic logic [MOVED_W-1:0] dist_sq(input logic signed [POS_W-1:0] ax, ay,
                                                   input logic signed [POS_W-1:0] bx, by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return MOVED_W'(dx * dx + dy * dy);
    endfunction

    // an object fails the pair if it is tracked and moved past the limit
    function automatic bit ran_off(input logic [ID_W-1:0] id);
        if (int'(id) >= N_OBJ) return 1'b0;
        return track_tab[id].tracked && (track_tab[id].moved > limit_sq);
    endfunction

    // read-modify-write of one table entry for a position update
    task automatic track_update(input logic [ID_W-1:0] id, input logic [SPACE_W-1:0] sp,
                                input logic [STAMP_W-1:0] st,
                                input logic signed [POS_W-1:0] px, py);
        logic [MOVED_W-1:0] d2;
        d2 = '0;
        if (int'(id) >= N_OBJ) return;
        if (track_tab[id].tracked && track_tab[id].space == sp &&
            st > track_tab[id].stamp && (st - track_tab[id].stamp) > gap_min)
            d2 = dist_sq(px, py, track_tab[id].x, track_tab[id].y);
        track_tab[id].tracked = 1'b1;
        track_tab[id].space   = sp;
        track_tab[id].stamp   = st;
        track_tab[id].x       = px;
        track_tab[id].y       = py;
        track_tab[id].moved   = d2;
    endtask

    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            for (int i = 0; i < N_OBJ; i++) track_tab[i].tracked = 1'b0;
            limit_sq = '0;
            gap_min  = '0;
            pass_due.delete();
            o_failures = 0;
            o_checked  = 0;
            o_blocked  = 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: limit_sq = i_cfg_data[MOVED_W-1:0];
                    CFG_MIN_GAP:   gap_min  = i_cfg_data[STAMP_W-1:0];
                    default: ;
                endcase
            end

            // result transaction against the oldest expectation
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (pass_due.size() == 0) begin
                    $error("pair_pass result with no query outstanding: got %0b",
                           i_out_mon.pair_pass);
                    o_failures++;
                end else begin
                    want = pass_due.pop_front();
                    if (i_out_mon.pair_pass !== want) begin
                        $error("pair_pass mismatch on result %0d: expected %0b, got %0b",
                               o_checked, want, i_out_mon.pair_pass);
                        o_failures++;
                    end
                    if (!want) o_blocked++;
                    o_checked++;
                end
            end

            // input transaction: predict
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.opcode == OP_QUERY)
                    pass_due.push_back(!(ran_off(i_in_mon.first_ant) ||
                                         ran_off(i_in_mon.second_ant)));
                else
                    track_update(i_in_mon.first_ant, i_in_mon.space_id, i_in_mon.frame_time,
                                 i_in_mon.pos_x, i_in_mon.pos_y);
            end
        end
        o_pending = pass_due.size();
    end

endmodule

### tb/displacement_gate_tb.sv
// top of the displacement gate testbench: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 1ps

module displacement_gate_tb;
    import dg_pkg::*;

    localparam int OBJ_COUNT = 1024;
    localparam int HOT_N     = 8;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    dg_in_if  in_ch ();
    dg_out_if out_ch ();

    int fail_count;
    int pending;
    int n_checked;
    int n_blocked;

    // stimulus bookkeeping
    bit                    calm      = 1'b0;
    bit                    stall_req = 1'b0;
    int                    n_update;
    int                    n_query;
    int                    n_settings;
    logic [STAMP_W-1:0]    cur_gap;
    int                    reach;

    // shadow of the few objects that get well-formed motion
    logic [ID_W-1:0]       pool_id    [HOT_N];
    logic [SPACE_W-1:0]    pool_space [HOT_N];
    logic [STAMP_W-1:0]    pool_stamp [HOT_N];
    longint                pool_x     [HOT_N];
    longint                pool_y     [HOT_N];

    displacement_gate #(
        .MAX_OBJECTS (OBJ_COUNT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    dg_pair_checker #(
        .N_OBJ (OBJ_COUNT)
    ) pair_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_mon   (in_ch),
        .i_out_mon  (out_ch),
        .o_failures (fail_count),
        .o_pending  (pending),
        .o_checked  (n_checked),
        .o_blocked  (n_blocked)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side flow control, with one long hold-off to back the block up
    initial begin
        bit stall_done;
        stall_done   = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_req && !stall_done) begin
                stall_done = 1'b1;
                // let the next phase start sending before holding off
                repeat (30) begin
                    out_ch.ready <= ($urandom_range(0, 99) >= 13);
                    @(negedge i_clk);
                end
                out_ch.ready <= 1'b0;
                repeat (80) @(negedge i_clk);
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 13);
            end
        end
    end

    function automatic logic [STAMP_W-1:0] rand62();
        return STAMP_W'({$urandom, $urandom});
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > 524287) v = 524287;
        if (v < -524288) v = -524288;
        return POS_W'(v);
    endfunction

    // present one transaction and wait until it is taken
    task automatic offer(input logic op, input logic [ID_W-1:0] a, b,
                         input logic [SPACE_W-1:0] sp, input logic [STAMP_W-1:0] st,
                         input logic signed [POS_W-1:0] px, py);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 13) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.first_ant  <= a;
        in_ch.second_ant <= b;
        in_ch.space_id   <= sp;
        in_ch.frame_time <= st;
        in_ch.pos_x      <= px;
        in_ch.pos_y      <= py;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (op == OP_QUERY) n_query++;
        else n_update++;
    endtask

    task automatic upd(input logic [ID_W-1:0] id, input logic [SPACE_W-1:0] sp,
                       input logic [STAMP_W-1:0] st, input logic signed [POS_W-1:0] px, py);
        offer(OP_UPDATE, id, ID_W'($urandom), sp, st, px, py);
    endtask

    // unused fields of a query carry noise
    task automatic qry(input logic [ID_W-1:0] a, b);
        offer(OP_QUERY, a, b, SPACE_W'($urandom), rand62(), POS_W'($urandom), POS_W'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // stop offering, wait for every result, then let update write-backs finish
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [STAMP_W-1:0] gap_pick();
        case ($urandom_range(0, 5))
            0:       return cur_gap;
            1:       return cur_gap + 1;
            2:       return cur_gap + $urandom_range(2, 5000);
            3:       return '0;
            4:       return rand62();
            default: return cur_gap - 1;
        endcase
    endfunction

    // move one hot object; a broken step changes space or goes back in time
    task automatic step_hot(input int s, input bit broken);
        logic [SPACE_W-1:0]      sp;
        logic [STAMP_W-1:0]      st;
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
        longint                  dx;
        longint                  dy;
        sp = pool_space[s];
        st = pool_stamp[s] + gap_pick();
        case ($urandom_range(0, 3))
            0: begin
                dx = reach;
                dy = 0;
            end
            1: begin
                dx = 0;
                dy = -(reach + 1);
            end
            default: begin
                dx = longint'($urandom_range(0, 2 * reach)) - reach;
                dy = longint'($urandom_range(0, 2 * reach)) - reach;
            end
        endcase
        if (broken) begin
            if ($urandom_range(0, 1)) sp = sp ^ SPACE_W'($urandom_range(1, 255));
            else st = pool_stamp[s] - $urandom_range(1, 1000);
        end
        nx = clamp_pos(pool_x[s] + dx);
        ny = clamp_pos(pool_y[s] + dy);
        upd(pool_id[s], sp, st, nx, ny);
        pool_space[s] = sp;
        pool_stamp[s] = st;
        pool_x[s]     = nx;
        pool_y[s]     = ny;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        return ($urandom_range(0, 99) < 70) ? pool_id[$urandom_range(0, HOT_N - 1)]
                                            : ID_W'($urandom);
    endfunction

    // one register setting followed by a random mix of traffic
    task automatic run_phase(input logic [CFG_DATA_W-1:0] thr, gap, input int reach_in,
                             input int n);
        int sel;
        settle();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_MIN_GAP, gap);
        cur_gap = gap[STAMP_W-1:0];
        reach   = reach_in;
        n_settings++;
        pool_id[0] = '0;
        pool_id[1] = ID_W'(OBJ_COUNT - 1);
        for (int i = 0; i < HOT_N; i++) begin
            if (i > 1) pool_id[i] = ID_W'($urandom_range(0, OBJ_COUNT - 1));
            pool_space[i] = SPACE_W'($urandom);
            pool_stamp[i] = rand62();
            pool_x[i]     = longint'($urandom_range(0, 600000)) - 300000;
            pool_y[i]     = longint'($urandom_range(0, 600000)) - 300000;
        end
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                step_hot($urandom_range(0, HOT_N - 1), 1'b0);
            else if (sel < 75)
                qry(pool_id[$urandom_range(0, HOT_N - 1)], pick_id());
            else if (sel < 85)
                upd(ID_W'($urandom), SPACE_W'($urandom), rand62(),
                    POS_W'($urandom), POS_W'($urandom));
            else if (sel < 93)
                step_hot($urandom_range(0, HOT_N - 1), 1'b1);
            else
                qry(ID_W'($urandom), ID_W'($urandom));
        end
    endtask

    // stimulus and verdict
    initial begin
        int r;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_THRESHOLD;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_UPDATE;
        in_ch.first_ant  = '0;
        in_ch.second_ant = '0;
        in_ch.space_id   = '0;
        in_ch.frame_time = '0;
        in_ch.pos_x      = '0;
        in_ch.pos_y      = '0;
        n_update   = 0;
        n_query    = 0;
        n_settings = 1;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: limit of 10 px, gap of 1 us
        write_reg(CFG_THRESHOLD, 25600);
        write_reg(CFG_MIN_GAP, 1000);
        cur_gap = 1000;
        qry(5, 6);                                   // empty table
        upd(5, 1, 1000, 0, 0);                       // new entry
        upd(5, 1, 2000, 160, 0);                     // gap equal to minimum, no motion
        qry(5, 5);
        upd(5, 1, 3001, 320, 0);                     // exactly on the limit
        qry(5, 7);
        upd(5, 1, 4002, 481, 0);                     // one step past the limit
        qry(5, 5);                                   // same object on both sides
        qry(7, 5);
        upd(5, 2, 9000, -5000, 7000);                // space changed
        qry(5, 1023);
        upd(1023, 255, {STAMP_W{1'b1}}, -524288, -524288);
        upd(1023, 255, 10, -524288, -524288);        // time going backwards
        qry(1023, 1023);
        upd(1023, 255, {STAMP_W{1'b1}}, 524287, 524287);  // largest displacement
        qry(0, 1023);
        qry(1023, 0);
        upd(0, 0, 0, 0, 0);
        upd(0, 0, 1001, -16, -16);
        qry(0, 0);
        upd(0, 0, 1001, 0, 0);                       // same timestamp
        qry(1023, 1);

        // random phases over several register settings, extremes first
        run_phase('0, '0, 3, 100);
        calm = 1'b1;
        run_phase(62'h200_0000_0000, {CFG_DATA_W{1'b1}}, 500000, 100);
        calm = 1'b0;
        r = $urandom_range(2, 3000);
        stall_req = 1'b1;
        run_phase(CFG_DATA_W'(longint'(r) * r), CFG_DATA_W'($urandom_range(0, 50000)), r, 100);
        run_phase(CFG_DATA_W'({$urandom, $urandom} & 64'h1FF_FFFF_FFFF) >> $urandom_range(0, 41),
                  rand62() >> $urandom_range(0, 61), $urandom_range(1, 500000), 100);
        r = $urandom_range(100, 200000);
        run_phase(CFG_DATA_W'(longint'(r) * r), CFG_DATA_W'($urandom_range(0, 5000)), r, 100);

        settle();
        repeat (20) @(negedge i_clk);

        $display("covered %0d updates and %0d pair queries across %0d register settings",
                 n_update, n_query, n_settings);
        $display("%0d pair results compared, %0d of them gated out", n_checked, n_blocked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
